[rtl/core/stable_priority_queue_defines.svh]
// Assertion helpers shared by the queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

[rtl/core/spq_pkg.sv]
package spq_pkg;

	localparam int DATA_WIDTH = 32;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage

[rtl/core/spq_chan_if.sv]
interface spq_req_if #(
	parameter int PRIO_WIDTH = 8
) ();
	logic                                      valid;
	logic                                      ready;
	spq_pkg::op_t                              op;
	logic signed [spq_pkg::DATA_WIDTH-1:0]     in_data;
	logic        [PRIO_WIDTH-1:0]              in_priority;

	modport source (output valid, op, in_data, in_priority, input ready);
	modport sink (input valid, op, in_data, in_priority, output ready);
endinterface

interface spq_rsp_if #(
	parameter int PRIO_WIDTH = 8,
	parameter int CNT_WIDTH  = 5
) ();
	logic                                      valid;
	logic                                      ready;
	spq_pkg::status_t                          status;
	logic signed [spq_pkg::DATA_WIDTH-1:0]     out_data;
	logic        [PRIO_WIDTH-1:0]              out_priority;
	logic        [CNT_WIDTH-1:0]               count;
	logic                                      is_empty;

	modport source (output valid, status, out_data, out_priority, count, is_empty,
		input ready);
	modport sink (input valid, status, out_data, out_priority, count, is_empty,
		output ready);
endinterface

[rtl/core/spq_cell.sv]
module spq_cell #(
	parameter int PRIO_WIDTH = 8
) (
	input  logic                              clk,
	input  spq_pkg::spq_ctrl_t                ctrl,
	input  logic                              occupied,
	input  logic [spq_pkg::DATA_WIDTH-1:0]    new_data,
	input  logic [PRIO_WIDTH-1:0]             new_prio,
	input  logic                              left_keep,
	input  logic [spq_pkg::DATA_WIDTH-1:0]    left_data,
	input  logic [PRIO_WIDTH-1:0]             left_prio,
	input  logic [spq_pkg::DATA_WIDTH-1:0]    right_data,
	input  logic [PRIO_WIDTH-1:0]             right_prio,
	output logic                              keep,
	output logic [spq_pkg::DATA_WIDTH-1:0]    data,
	output logic [PRIO_WIDTH-1:0]             prio
);

	logic [spq_pkg::DATA_WIDTH-1:0] data_q, data_d;
	logic [PRIO_WIDTH-1:0]          prio_q, prio_d;

	// An occupied entry that is not worse than the new one stays put, which keeps
	// equal priorities in arrival order.
	assign keep = occupied && (prio_q <= new_prio);

	always_comb begin
		data_d = data_q;
		prio_d = prio_q;
		priority if (ctrl.enq && !keep) begin
			if (left_keep) begin
				data_d = new_data;
				prio_d = new_prio;
			end else begin
				data_d = left_data;
				prio_d = left_prio;
			end
		end else if (ctrl.deq) begin
			data_d = right_data;
			prio_d = right_prio;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		prio_q <= prio_d;
	end

	assign data = data_q;
	assign prio = prio_q;

endmodule

[rtl/core/stable_priority_queue.sv]
// Sorted priority queue of DEPTH entries built as a chain of cells, each holding
// one entry, with the head (smallest priority, oldest among equals) in cell zero.
// Every cell compares its priority with an incoming one in parallel, so an
// enqueue or a dequeue updates every cell at once, and one transaction can be
// accepted on every clock unless the request side stalls. The result of a
// transaction appears in the output register on the following cycle; the
// request side stalls only while that register holds a result the consumer
// has not taken. A dequeue from an empty queue reports an empty status, and
// an enqueue into a full queue is dropped and reports a full status.
// Entries have no reset; only the fill count and response valid flag are reset.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
	parameter int DEPTH      = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int CNT_WIDTH = $clog2(DEPTH + 1);
	localparam int DW        = spq_pkg::DATA_WIDTH;

	logic [CNT_WIDTH-1:0] count_q, count_d;
	logic                 fire, full, empty;
	spq_pkg::spq_ctrl_t   ctrl;

	logic                  cell_keep [DEPTH];
	logic [DW-1:0]         cell_data [DEPTH];
	logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
	logic                  lk [DEPTH];
	logic [DW-1:0]         ld [DEPTH];
	logic [PRIO_WIDTH-1:0] lp [DEPTH];
	logic [DW-1:0]         rd [DEPTH];
	logic [PRIO_WIDTH-1:0] rp [DEPTH];

	logic                  rsp_valid_q;
	spq_pkg::status_t      status_q;
	logic [DW-1:0]         out_data_q;
	logic [PRIO_WIDTH-1:0] out_prio_q;
	logic [CNT_WIDTH-1:0]  out_count_q;
	logic                  is_empty_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CNT_WIDTH'(DEPTH));
	assign empty     = (count_q == '0);

	assign ctrl.enq = fire && (req.op == spq_pkg::OP_ENQ) && !full;
	assign ctrl.deq = fire && (req.op == spq_pkg::OP_DEQ) && !empty;

	always_comb begin
		count_d = count_q;
		if (ctrl.enq) begin
			count_d = count_q + CNT_WIDTH'(1);
		end else if (ctrl.deq) begin
			count_d = count_q - CNT_WIDTH'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign lk[i] = 1'b1;
			assign ld[i] = req.in_data;
			assign lp[i] = req.in_priority;
		end else begin : g_body
			assign lk[i] = cell_keep[i-1];
			assign ld[i] = cell_data[i-1];
			assign lp[i] = cell_prio[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rd[i] = cell_data[i];
			assign rp[i] = cell_prio[i];
		end else begin : g_next
			assign rd[i] = cell_data[i+1];
			assign rp[i] = cell_prio[i+1];
		end

		spq_cell #(
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > CNT_WIDTH'(i)),
			.new_data   (req.in_data),
			.new_prio   (req.in_priority),
			.left_keep  (lk[i]),
			.left_data  (ld[i]),
			.left_prio  (lp[i]),
			.right_data (rd[i]),
			.right_prio (rp[i]),
			.keep       (cell_keep[i]),
			.data       (cell_data[i]),
			.prio       (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (req.op)
				spq_pkg::OP_ENQ: status_q <= full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
				spq_pkg::OP_DEQ: status_q <= empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
				default:         status_q <= spq_pkg::STATUS_OK;
			endcase
			out_data_q  <= ctrl.deq ? cell_data[0] : '0;
			out_prio_q  <= ctrl.deq ? cell_prio[0] : '0;
			out_count_q <= count_d;
			is_empty_q  <= (count_d == '0);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_data     = out_data_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.count        = out_count_q;
	assign rsp.is_empty     = is_empty_q;

	`SPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_WIDTH'(DEPTH))
	`SPQ_ASSERT_NEXT(a_idle_count, clk, arst_n, !fire, $stable(count_q))
	`SPQ_ASSERT_NEXT(a_full_drop, clk, arst_n, fire && req.op == spq_pkg::OP_ENQ && full, status_q == spq_pkg::STATUS_FULL && $stable(count_q))
	`SPQ_ASSERT_NEXT(a_empty_deq, clk, arst_n, fire && req.op == spq_pkg::OP_DEQ && empty, status_q == spq_pkg::STATUS_EMPTY && out_count_q == '0)
	`SPQ_ASSERT_SAME(a_stall, clk, arst_n, rsp_valid_q && !rsp.ready, !req.ready)

endmodule
